>>> design/garm_pkg.sv
// Shared constants and types for the guest address region mapper.
package garm_pkg;
    localparam logic [2:0] CON_OTHER = 3'd0;
    localparam logic [2:0] CON_NES   = 3'd1;
    localparam logic [2:0] CON_GBC   = 3'd2;
    localparam logic [2:0] CON_NGP   = 3'd3;
    localparam logic [2:0] CON_GBA   = 3'd4;
    localparam logic [2:0] CON_PCE   = 3'd5;
    localparam logic [2:0] CON_SNES  = 3'd6;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    localparam logic [2:0] REG_CONSOLE = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd1;
    localparam logic [2:0] REG_SYSRAM  = 3'd2;
    localparam logic [2:0] REG_SAVERAM = 3'd3;
    localparam logic [2:0] REG_VIDRAM  = 3'd4;
    localparam logic [2:0] REG_CLKRAM  = 3'd5;

    localparam logic [31:0] NES_MIR_LO  = 32'h0000_0800;
    localparam logic [31:0] NES_MIR_HI  = 32'h0000_2000;
    localparam logic [31:0] NES_MIR_MSK = 32'h0000_07ff;
    localparam logic [31:0] GBC_ECHO_LO = 32'h0000_e000;
    localparam logic [31:0] GBC_ECHO_HI = 32'h0000_fdff;
    localparam logic [31:0] GBC_SHIFT   = 32'h0000_2000;
    localparam logic [31:0] NGP_SHIFT   = 32'h0000_4000;
    localparam logic [31:0] GBA_SPLIT   = 32'h0000_8000;
    localparam logic [31:0] GBA_LO_ADD  = 32'h0300_0000;
    localparam logic [31:0] GBA_HI_ADD  = 32'h0200_0000;
    localparam logic [31:0] PCE_ADD     = 32'h001f_0000;
    localparam logic [31:0] SNES_SPLIT  = 32'h0002_0000;
    localparam logic [31:0] SNES_LO_ADD = 32'h007e_0000;
    localparam logic [31:0] SNES_HI_ADD = 32'h0000_6000;
    localparam logic [31:0] NES_BANK0   = 32'h0000_6000;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] sel;
        logic [31:0] disc;
        logic [31:0] dmask;
        logic [31:0] length;
        logic [31:0] offset;
    } t_desc;
endpackage

>>> design/guest_address_region_mapper.sv
// Top level of the guest address region mapper: descriptor table and translate pipeline.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  command | i_start / o_busy          | i_command, i_entry_index, descriptor, i_address
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  result  | o_strobe (one cycle)      | o_found, o_bank_index, o_mapped_offset
//
// One command word enters per clock; o_busy stays low. A translate passes six register
// stages (adjust, match scan or bank walk, subtract and mask, two extract stages, top-bit
// trim with offset add), the last of which drives o_strobe. Loads are registered on
// acceptance and write the table the cycle after, in step with the match stage, and
// yield no result. Reset (synchronous, active low) clears the configuration and all
// stage valid bits; the receiver cannot stall.
module guest_address_region_mapper #(
    parameter int MAX_REGIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_region_start,
    input  logic [31:0] i_region_select,
    input  logic [31:0] i_region_disconnect,
    input  logic [31:0] i_region_disconnect_mask,
    input  logic [31:0] i_region_length,
    input  logic [31:0] i_region_offset,
    input  logic [31:0] i_address,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_found,
    output logic [3:0]  o_bank_index,
    output logic [31:0] o_mapped_offset
);
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    logic [2:0]  r_console;
    logic [4:0]  r_count;
    logic [31:0] r_bsize [4];
    garm_pkg::t_desc r_tab [MAX_REGIONS];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_console <= garm_pkg::CON_OTHER;
            r_count   <= '0;
            for (int b = 0; b < 4; b++) r_bsize[b] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                garm_pkg::REG_CONSOLE: r_console <= i_cfg_data[2:0];
                garm_pkg::REG_COUNT:   r_count   <= i_cfg_data[4:0];
                garm_pkg::REG_SYSRAM:  r_bsize[0] <= i_cfg_data;
                garm_pkg::REG_SAVERAM: r_bsize[1] <= i_cfg_data;
                garm_pkg::REG_VIDRAM:  r_bsize[2] <= i_cfg_data;
                garm_pkg::REG_CLKRAM:  r_bsize[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cumulative fallback bank bases; after bank 0 the NES skips a fixed window instead.
    logic [31:0] base0;
    logic [31:0] r_cum [4];
    assign base0 = (r_console == garm_pkg::CON_NES) ? garm_pkg::NES_BANK0 : r_bsize[0];
    always_ff @(posedge i_clk) begin
        r_cum[0] <= base0;
        r_cum[1] <= base0 + r_bsize[1];
        r_cum[2] <= base0 + r_bsize[1] + r_bsize[2];
        r_cum[3] <= base0 + r_bsize[1] + r_bsize[2] + r_bsize[3];
    end

    // Descriptor table: register an accepted load, then write its slot the cycle after;
    // out-of-range slots drop.
    logic            r_ld1;
    logic [IW-1:0]   r_ld_slot;
    garm_pkg::t_desc r_ld_desc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ld1 <= 1'b0;
        else          r_ld1 <= i_start && i_command == garm_pkg::CMD_LOAD
                               && 32'(i_entry_index) < 32'(MAX_REGIONS);
        r_ld_slot <= IW'(i_entry_index);
        r_ld_desc <= '{i_region_start, i_region_select,
            i_region_disconnect, i_region_disconnect_mask,
            i_region_length, i_region_offset};
    end

    always_ff @(posedge i_clk) begin
        if (r_ld1) begin
            r_tab[r_ld_slot] <= r_ld_desc;
        end
    end

    // Stage 1: console adjustments.
    logic        go;
    logic [31:0] n_v1;
    logic [6:0]  count_sat;
    assign go = i_start && i_command == garm_pkg::CMD_TRANSLATE;
    assign count_sat = ({2'b0, r_count} > 7'(MAX_REGIONS)) ? 7'(MAX_REGIONS)
                                                             : {2'b0, r_count};

    always_comb begin
        n_v1 = i_address;
        case (r_console)
            garm_pkg::CON_NES:
                if (n_v1 >= garm_pkg::NES_MIR_LO && n_v1 < garm_pkg::NES_MIR_HI)
                    n_v1 = n_v1 & garm_pkg::NES_MIR_MSK;
            garm_pkg::CON_GBC:
                if (n_v1 >= garm_pkg::GBC_ECHO_LO && n_v1 <= garm_pkg::GBC_ECHO_HI)
                    n_v1 = n_v1 - garm_pkg::GBC_SHIFT;
            garm_pkg::CON_NGP: n_v1 = n_v1 - garm_pkg::NGP_SHIFT;
            default: ;
        endcase
        if (count_sat != '0) begin
            case (r_console)
                garm_pkg::CON_GBA:
                    n_v1 = (n_v1 < garm_pkg::GBA_SPLIT) ? n_v1 + garm_pkg::GBA_LO_ADD
                         : n_v1 + garm_pkg::GBA_HI_ADD - garm_pkg::GBA_SPLIT;
                garm_pkg::CON_PCE: n_v1 = n_v1 + garm_pkg::PCE_ADD;
                garm_pkg::CON_SNES:
                    n_v1 = (n_v1 < garm_pkg::SNES_SPLIT) ? n_v1 + garm_pkg::SNES_LO_ADD
                         : n_v1 + garm_pkg::SNES_HI_ADD - garm_pkg::SNES_SPLIT;
                default: ;
            endcase
        end
    end

    logic        r_vld1;
    logic [31:0] r_v1;
    logic [6:0]  r_cnt1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld1 <= 1'b0;
        else          r_vld1 <= go;
        r_v1   <= n_v1;
        r_cnt1 <= count_sat;
    end

    // Stage 2: priority match over descriptors, or fallback bank walk against the
    // cumulative bases, all banks in parallel.
    logic        n_hit2;
    logic [3:0]  n_bank2;
    logic [31:0] n_v2;
    logic        n_fb2;
    logic [31:0] n_fd [4];
    garm_pkg::t_desc n_d2;
    always_comb begin
        n_hit2  = 1'b0;
        n_bank2 = '0;
        n_d2    = r_tab[0];
        n_fb2   = (r_cnt1 == '0);
        n_v2    = r_v1;
        n_fd[0] = r_v1;
        for (int b = 1; b < 4; b++) n_fd[b] = r_v1 - r_cum[b-1];
        if (!n_fb2) begin
            for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
                if (7'(i) < r_cnt1 && ((r_tab[i].start ^ r_v1) & r_tab[i].sel) == '0) begin
                    n_hit2  = 1'b1;
                    n_bank2 = 4'(i);
                    n_d2    = r_tab[i];
                end
            end
        end else begin
            n_v2 = r_v1 - r_cum[3];
            for (int b = 3; b >= 0; b--) begin
                if (n_fd[b] < r_bsize[b]) begin
                    n_hit2  = 1'b1;
                    n_bank2 = 4'(b);
                    n_v2    = n_fd[b];
                end
            end
        end
    end

    logic        r_vld2, r_hit2, r_fb2;
    logic [3:0]  r_bank2;
    logic [31:0] r_v2;
    garm_pkg::t_desc r_d2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld2 <= 1'b0;
        else          r_vld2 <= r_vld1;
        r_hit2  <= n_hit2;
        r_fb2   <= n_fb2;
        r_bank2 <= n_bank2;
        r_v2    <= n_v2;
        r_d2    <= n_d2;
    end

    // Stage 3: subtract start and apply the disconnect mask.
    logic        r_vld3, r_hit3, r_fb3;
    logic [3:0]  r_bank3;
    logic [31:0] r_v3, r_r3, r_disc3, r_len3, r_off3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld3 <= 1'b0;
        else          r_vld3 <= r_vld2;
        r_hit3  <= r_hit2;
        r_fb3   <= r_fb2;
        r_bank3 <= r_bank2;
        r_v3    <= r_v2;
        r_r3    <= (r_v2 - r_d2.start) & r_d2.dmask;
        r_disc3 <= r_d2.disc;
        r_len3  <= r_d2.length;
        r_off3  <= r_d2.offset;
    end

    // Stages 4-5: bit extract; carry side data alongside.
    logic [31:0] ext;
    garm_extract u_extract (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_val (r_r3),
        .i_mask(r_disc3),
        .o_res (ext)
    );

    logic [1:0]  r_vld45, r_hit45, r_fb45;
    logic [3:0]  r_bank45 [2];
    logic [31:0] r_v45 [2], r_len45 [2], r_off45 [2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld45 <= '0;
        else          r_vld45 <= {r_vld45[0], r_vld3};
        r_hit45     <= {r_hit45[0], r_hit3};
        r_fb45      <= {r_fb45[0], r_fb3};
        r_bank45[0] <= r_bank3;  r_bank45[1] <= r_bank45[0];
        r_v45[0]    <= r_v3;     r_v45[1]    <= r_v45[0];
        r_len45[0]  <= r_len3;   r_len45[1]  <= r_len45[0];
        r_off45[0]  <= r_off3;   r_off45[1]  <= r_off45[0];
    end

    // Stage 6: on a descriptor hit, drop the top set bit when not below length and add offset.
    logic [31:0] smear, trimmed, n_out;
    always_comb begin
        smear = ext;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        trimmed = (ext >= r_len45[1]) ? ext - (smear ^ (smear >> 1)) : ext;
        n_out = (!r_fb45[1] && r_hit45[1]) ? trimmed + r_off45[1] : r_v45[1];
    end

    logic r_vld6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld6 <= 1'b0;
        else          r_vld6 <= r_vld45[1];
        o_found         <= r_hit45[1];
        o_bank_index    <= r_hit45[1] ? r_bank45[1] : 4'd0;
        o_mapped_offset <= n_out;
    end
    assign o_strobe = r_vld6;

    // A result follows each translate.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> ##5 o_strobe) else $error("translate result lost");
    a_noload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_command == garm_pkg::CMD_LOAD) |-> ##1 !r_vld1)
        else $error("load produced a result");
    a_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> o_bank_index == 4'd0)
        else $error("bank index on miss");
endmodule

>>> design/garm_extract.sv
// Pipelined parallel bit extract: keep the bits of the value where the mask is 0.
module garm_extract (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_val,
    input  logic [31:0] i_mask,
    output logic [31:0] o_res
);
    // Two stages of 16 bits each; the upper half lands at the count of kept low bits.
    logic [15:0] n_lo;
    logic [4:0]  n_cnt;
    logic [15:0] r_lo;
    logic [4:0]  r_cnt;
    logic [15:0] r_hiv;
    logic [15:0] r_him;
    logic [15:0] n_hi;
    logic [4:0]  n_hcnt;
    logic [31:0] r_res;

    always_comb begin
        n_lo  = '0;
        n_cnt = '0;
        for (int i = 0; i < 16; i++) begin
            if (!i_mask[i]) begin
                n_lo[n_cnt[3:0]] = i_val[i];
                n_cnt = n_cnt + 5'd1;
            end
        end
        n_hi   = '0;
        n_hcnt = '0;
        for (int i = 0; i < 16; i++) begin
            if (!r_him[i]) begin
                n_hi[n_hcnt[3:0]] = r_hiv[i];
                n_hcnt = n_hcnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= n_lo;
            r_cnt <= n_cnt;
            r_hiv <= i_val[31:16];
            r_him <= i_mask[31:16];
            r_res <= {16'd0, r_lo} | ({16'd0, n_hi} << r_cnt);
        end
    end

    assign o_res = r_res;
endmodule

>>> test/tb.sv
// Self-checking testbench for the guest address region mapper.
module tb;
    typedef struct {
        logic        found;
        logic [3:0]  bank;
        logic [31:0] offset;
    } t_map;

    typedef enum logic [1:0] {ROW_LOAD, ROW_XLATE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [3:0]      slot;       // load slot, or register index for ROW_CFG
        garm_pkg::t_desc desc;
        logic [31:0]     value;      // address, or register data for ROW_CFG
        bit              typed;      // expected result given in the row
        t_map            result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_command = garm_pkg::CMD_LOAD;
    logic [3:0]  i_entry_index = '0;
    logic [31:0] i_region_start = '0;
    logic [31:0] i_region_select = '0;
    logic [31:0] i_region_disconnect = '0;
    logic [31:0] i_region_disconnect_mask = '0;
    logic [31:0] i_region_length = '0;
    logic [31:0] i_region_offset = '0;
    logic [31:0] i_address = '0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_cfg_ready;
    logic        o_strobe;
    logic        o_found;
    logic [3:0]  o_bank_index;
    logic [31:0] o_mapped_offset;

    guest_address_region_mapper u_dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_start                  (i_start),
        .o_busy                   (o_busy),
        .i_command                (i_command),
        .i_entry_index            (i_entry_index),
        .i_region_start           (i_region_start),
        .i_region_select          (i_region_select),
        .i_region_disconnect      (i_region_disconnect),
        .i_region_disconnect_mask (i_region_disconnect_mask),
        .i_region_length          (i_region_length),
        .i_region_offset          (i_region_offset),
        .i_address                (i_address),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data),
        .o_strobe                 (o_strobe),
        .o_found                  (o_found),
        .o_bank_index             (o_bank_index),
        .o_mapped_offset          (o_mapped_offset)
    );

    always #1 i_clk = ~i_clk;

    // Mirror of the block: descriptor table and configuration registers.
    garm_pkg::t_desc slot_table [16];
    logic [2:0]  mdl_console;
    logic [4:0]  mdl_count;
    logic [31:0] mdl_bank_size [4];

    t_map pending_maps [$];
    int   mismatches = 0;
    bit   no_gaps;           // burst mode: no idle draw between words
    t_row rows [$];

    // Keep the bits of v where m is 0, packed toward bit 0.
    function automatic logic [31:0] extract_bits(logic [31:0] v, logic [31:0] m);
        logic [31:0] r;
        int          pos;
        r = '0;
        pos = 0;
        for (int i = 0; i < 32; i++) begin
            if (!m[i]) begin
                r[pos] = v[i];
                pos++;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] highest_bit(logic [31:0] v);
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) return 32'h1 << i;
        end
        return '0;
    endfunction

    // Work out the translation of one guest address against the mirror state.
    function automatic t_map map_address(logic [31:0] addr);
        t_map        m;
        logic [31:0] v;
        logic [31:0] r;
        int          n;
        v = addr;
        m.found = 1'b0;
        m.bank = '0;
        case (mdl_console)
            garm_pkg::CON_NES:
                if (v >= garm_pkg::NES_MIR_LO && v < garm_pkg::NES_MIR_HI)
                    v &= garm_pkg::NES_MIR_MSK;
            garm_pkg::CON_GBC:
                if (v >= garm_pkg::GBC_ECHO_LO && v <= garm_pkg::GBC_ECHO_HI)
                    v -= garm_pkg::GBC_SHIFT;
            garm_pkg::CON_NGP: v -= garm_pkg::NGP_SHIFT;
            default: ;
        endcase
        n = (mdl_count > 16) ? 16 : mdl_count;
        if (n != 0) begin
            case (mdl_console)
                garm_pkg::CON_GBA:
                    v = (v < garm_pkg::GBA_SPLIT) ? v + garm_pkg::GBA_LO_ADD
                      : v + garm_pkg::GBA_HI_ADD - garm_pkg::GBA_SPLIT;
                garm_pkg::CON_PCE:  v += garm_pkg::PCE_ADD;
                garm_pkg::CON_SNES:
                    v = (v < garm_pkg::SNES_SPLIT) ? v + garm_pkg::SNES_LO_ADD
                      : v + garm_pkg::SNES_HI_ADD - garm_pkg::SNES_SPLIT;
                default: ;
            endcase
            for (int i = 0; i < n; i++) begin
                if (!m.found && ((slot_table[i].start ^ v) & slot_table[i].sel) == 0) begin
                    r = (v - slot_table[i].start) & slot_table[i].dmask;
                    r = extract_bits(r, slot_table[i].disc);
                    if (r >= slot_table[i].length) r -= highest_bit(r);
                    v = r + slot_table[i].offset;
                    m.found = 1'b1;
                    m.bank = i[3:0];
                end
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (!m.found) begin
                    if (v < mdl_bank_size[i]) begin
                        m.found = 1'b1;
                        m.bank = i[3:0];
                    end else if (i == 0 && mdl_console == garm_pkg::CON_NES) begin
                        v -= garm_pkg::NES_BANK0;
                    end else begin
                        v -= mdl_bank_size[i];
                    end
                end
            end
        end
        m.offset = v;
        return m;
    endfunction

    function automatic void mirror_config(logic [2:0] idx, logic [31:0] data);
        case (idx)
            garm_pkg::REG_CONSOLE: mdl_console = data[2:0];
            garm_pkg::REG_COUNT:   mdl_count = data[4:0];
            garm_pkg::REG_SYSRAM:  mdl_bank_size[0] = data;
            garm_pkg::REG_SAVERAM: mdl_bank_size[1] = data;
            garm_pkg::REG_VIDRAM:  mdl_bank_size[2] = data;
            garm_pkg::REG_CLKRAM:  mdl_bank_size[3] = data;
            default: ;
        endcase
    endfunction

    // Hold a config word until the port takes it; sample ready at the falling edge.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        bit taken;
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do begin
            taken = o_cfg_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!taken);
        i_cfg_valid = 1'b0;
        mirror_config(idx, data);
    endtask

    // Let the pipeline drain before the configuration moves.
    task automatic drain();
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Drive one command word; record the load or the expected translation on acceptance.
    task automatic send_word(logic cmd, logic [3:0] slot, garm_pkg::t_desc d,
                             logic [31:0] addr, bit typed, t_map typed_map);
        bit taken;
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        i_start = 1'b1;
        i_command = cmd;
        i_entry_index = slot;
        i_region_start = d.start;
        i_region_select = d.sel;
        i_region_disconnect = d.disc;
        i_region_disconnect_mask = d.dmask;
        i_region_length = d.length;
        i_region_offset = d.offset;
        i_address = addr;
        do begin
            taken = !o_busy;
            @(posedge i_clk);
            if (!taken) @(negedge i_clk);
        end while (!taken);
        if (cmd == garm_pkg::CMD_LOAD) slot_table[slot] = d;
        else pending_maps.push_back(typed ? typed_map : map_address(addr));
        // drop start at the next falling edge
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // Compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_map want;
        if (i_rst_n && o_strobe) begin
            if (pending_maps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b bank=%0d offset=%h",
                             o_found, o_bank_index, o_mapped_offset);
            end else begin
                want = pending_maps.pop_front();
                if (o_found !== want.found || o_bank_index !== want.bank
                        || o_mapped_offset !== want.offset) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp found=%0b bank=%0d offset=%h, got %0b %0d %h",
                                 want.found, want.bank, want.offset,
                                 o_found, o_bank_index, o_mapped_offset);
                end
            end
        end
    end

    function automatic garm_pkg::t_desc random_desc();
        garm_pkg::t_desc d;
        int              k;
        k = $urandom_range(0, 31);
        d.start = $urandom;
        case ($urandom_range(0, 7))
            0:       d.sel = '0;
            1:       d.sel = '1;
            default: d.sel = $urandom & ~((32'h1 << k) - 1);
        endcase
        d.disc = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom & $urandom & $urandom);
        d.dmask = ($urandom_range(0, 1) == 0) ? 32'hffff_ffff : $urandom;
        case ($urandom_range(0, 3))
            0:       d.length = '0;
            1:       d.length = '1;
            2:       d.length = $urandom;
            default: d.length = 32'h1 << k;
        endcase
        d.offset = $urandom;
        return d;
    endfunction

    // Undo the per-console shift roughly so that a chosen adjusted value gets hit.
    function automatic logic [31:0] raw_for(logic [31:0] v);
        case (mdl_console)
            garm_pkg::CON_NGP:  return v + garm_pkg::NGP_SHIFT;
            garm_pkg::CON_GBA:
                return (mdl_count != 0) ? v - garm_pkg::GBA_HI_ADD + garm_pkg::GBA_SPLIT : v;
            garm_pkg::CON_PCE:  return (mdl_count != 0) ? v - garm_pkg::PCE_ADD : v;
            garm_pkg::CON_SNES:
                return (mdl_count != 0) ? v - garm_pkg::SNES_HI_ADD + garm_pkg::SNES_SPLIT
                                        : v;
            default:  return v;
        endcase
    endfunction

    function automatic logic [31:0] pick_address();
        logic [31:0] edges [12];
        int          s;
        edges = '{32'h0, 32'hffff_ffff, 32'h7ff, 32'h800, 32'h1fff, 32'h2000, 32'hdfff,
                  32'he000, 32'hfdff, 32'h7fff, 32'h8000, 32'h2_0000};
        if (mdl_count == 0) begin
            case ($urandom_range(0, 3))
                0:       return edges[$urandom_range(0, 11)];
                1:       return $urandom;
                default: return $urandom_range(0, 32'h2_0000);
            endcase
        end
        case ($urandom_range(0, 9))
            0:       return edges[$urandom_range(0, 11)];
            1:       return $urandom;
            default: begin
                s = $urandom_range(0, ((mdl_count > 16) ? 16 : mdl_count) - 1);
                return raw_for(slot_table[s].start ^ ($urandom & ~slot_table[s].sel));
            end
        endcase
    endfunction

    function automatic t_row mk_load(logic [3:0] slot, garm_pkg::t_desc d);
        t_row r;
        r = '{kind: ROW_LOAD, slot: slot, desc: d, value: '0, typed: 0, result: '{0, 0, 0}};
        return r;
    endfunction

    function automatic t_row mk_xlate(logic [31:0] addr, bit typed, t_map m);
        t_row r;
        r = '{kind: ROW_XLATE, slot: '0, desc: '0, value: addr, typed: typed, result: m};
        return r;
    endfunction

    function automatic t_row mk_cfg(logic [2:0] idx, logic [31:0] data);
        t_row r;
        r = '{kind: ROW_CFG, slot: {1'b0, idx}, desc: '0, value: data, typed: 0,
              result: '{0, 0, 0}};
        return r;
    endfunction

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        garm_pkg::t_desc d;
        t_row            row;
        logic [31:0]     cnt_list [8];
        logic [31:0]     data;
        t_map            none;
        none = '{0, 0, 0};
        mdl_console = garm_pkg::CON_OTHER;
        mdl_count = '0;
        for (int i = 0; i < 4; i++) mdl_bank_size[i] = '0;
        no_gaps = 0;

        // Directed table. After reset every bank is empty, so nothing matches.
        rows.push_back(mk_xlate(32'h0, 1, '{0, 0, 32'h0}));
        rows.push_back(mk_xlate(32'hffff_ffff, 1, '{0, 0, 32'hffff_ffff}));
        // Slots 0..14: 256 MB windows keyed on the top nibble; slot 0 has zero length.
        for (int i = 0; i < 15; i++) begin
            d = '{start: i << 28, sel: 32'hf000_0000, disc: '0, dmask: '1,
                  length: (i == 0) ? 32'h0 : 32'h0800_0000, offset: i};
            rows.push_back(mk_load(i[3:0], d));
        end
        rows.push_back(mk_load(4'd15, '{start: 32'hf000_0000, sel: '1, disc: 32'h0000_ffff,
                                        dmask: '1, length: '1, offset: '1}));
        // NES mirror folds into bank 0; past bank 0 the fixed 0x6000 is taken off.
        rows.push_back(mk_cfg(garm_pkg::REG_CONSOLE, 32'(garm_pkg::CON_NES)));
        rows.push_back(mk_cfg(garm_pkg::REG_SYSRAM, 32'h800));
        rows.push_back(mk_xlate(32'h0fff, 1, '{1, 0, 32'h7ff}));
        rows.push_back(mk_xlate(32'h6000, 1, '{0, 0, 32'h0}));
        // Count above the table size saturates; console code 7 acts as other.
        rows.push_back(mk_cfg(garm_pkg::REG_COUNT, 32'd31));
        rows.push_back(mk_cfg(garm_pkg::REG_CONSOLE, 32'd7));
        rows.push_back(mk_xlate(32'h3000_0005, 1, '{1, 3, 32'h8}));
        rows.push_back(mk_xlate(32'h0000_0009, 1, '{1, 0, 32'h1}));
        rows.push_back(mk_cfg(garm_pkg::REG_CONSOLE, 32'(garm_pkg::CON_GBA)));
        rows.push_back(mk_xlate(32'h0, 1, '{1, 0, 32'h0100_0000}));
        rows.push_back(mk_cfg(garm_pkg::REG_CONSOLE, 32'(garm_pkg::CON_OTHER)));
        rows.push_back(mk_xlate(32'hf000_0000, 1, '{1, 15, 32'hffff_ffff}));
        // Unused register indexes are no-ops.
        rows.push_back(mk_cfg(3'd6, 32'hffff_ffff));
        rows.push_back(mk_cfg(3'd7, 32'hffff_ffff));
        rows.push_back(mk_xlate(32'h1234_5678, 0, none));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            row = rows[k];
            case (row.kind)
                ROW_CFG: begin
                    drain();
                    write_reg(row.slot[2:0], row.value);
                end
                ROW_LOAD:  send_word(garm_pkg::CMD_LOAD, row.slot, row.desc, '0, 0, none);
                default:   send_word(garm_pkg::CMD_TRANSLATE, '0, '0, row.value,
                                     row.typed, row.result);
            endcase
        end

        // Random phases: new configuration each time, then a mix of loads and translates.
        cnt_list = '{32'd0, 32'd16, 32'd17, 32'd1, 32'hffff_ffe0, 32'd5, 32'd0, 32'd31};
        for (int p = 0; p < 14; p++) begin
            drain();
            no_gaps = ($urandom_range(0, 3) == 0);
            write_reg(garm_pkg::REG_CONSOLE, (p < 8) ? p : $urandom);
            data = (p < 8) ? cnt_list[p] : $urandom;
            write_reg(garm_pkg::REG_COUNT, data);
            for (int b = 0; b < 4; b++) begin
                case ($urandom_range(0, 5))
                    0:       data = '0;
                    1:       data = '1;
                    2:       data = $urandom;
                    default: data = $urandom_range(0, 32'h8000);
                endcase
                write_reg(3'(garm_pkg::REG_SYSRAM + b), data);
            end
            for (int n = 0; n < 55; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_word(garm_pkg::CMD_LOAD, 4'($urandom_range(0, 15)), random_desc(),
                              $urandom, 0, none);
                else
                    send_word(garm_pkg::CMD_TRANSLATE, 4'($urandom), random_desc(),
                              pick_address(), 0, none);
            end
        end

        drain();
        if (mismatches == 0 && pending_maps.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/garm_pkg.sv
design/garm_extract.sv
design/guest_address_region_mapper.sv
test/tb.sv
